### hw/rtl/kurtosis_frame_drop_decider_top_macros.svh
// Assertion macros used by the kurtosis frame drop decider output buffer.
// Depends on nothing; files that check their own logic include it.
`ifndef KURTOSIS_FRAME_DROP_DECIDER_TOP_MACROS_SVH
`define KURTOSIS_FRAME_DROP_DECIDER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define KFDD_ASSERT_IMPLY(name, clock, reset, a, b) \
  name: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
    else $error("kfdd assertion failed");
`define KFDD_ASSERT_NEXT(name, clock, reset, a, b) \
  name: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
    else $error("kfdd assertion failed");
`else
`define KFDD_ASSERT_IMPLY(name, clock, reset, a, b)
`define KFDD_ASSERT_NEXT(name, clock, reset, a, b)
`endif
`endif

### hw/rtl/kfdd_pkg.sv
// Types and constants of the kurtosis frame drop decider.
// Depends on nothing; every other RTL file but the assertion macro header uses it.
`timescale 1ns / 1ps
`default_nettype none
package kfdd_pkg;

  localparam int KURT_W      = 20;
  localparam int FACTOR_W    = 20;
  localparam int SIGMA_W     = 24;
  localparam int THRESH_W    = 24;
  localparam int LIMIT_W     = 11;
  localparam int CUT_COUNT_W = 2;
  localparam int CUT_SLOTS   = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  // Unity in the Q4.16 kurtosis format.
  localparam logic [KURT_W-1:0] ONE_Q16 = 20'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DROP_ENABLE = 3'd0,
    REG_CUT_COUNT   = 3'd1,
    REG_THRESHOLD_A = 3'd2,
    REG_THRESHOLD_B = 3'd3,
    REG_THRESHOLD_C = 3'd4,
    REG_LIMIT_A     = 3'd5,
    REG_LIMIT_B     = 3'd6,
    REG_LIMIT_C     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                                drop_enable;
    logic [CUT_COUNT_W-1:0]              cut_count;
    logic [CUT_SLOTS-1:0][THRESH_W-1:0]  thresholds;
    logic [CUT_SLOTS-1:0][LIMIT_W-1:0]   limits;
  } cfg_t;

  typedef struct packed {
    logic [SIGMA_W-1:0] sigma;
    logic               last;
  } sigma_item_t;

  typedef struct packed {
    logic                 frame_pass;
    logic [CUT_SLOTS-1:0] failed_cuts;
  } result_t;

endpackage
`default_nettype wire

### hw/rtl/kfdd_in_if.sv
// Sample channel of the kurtosis frame drop decider: valid, ready, payload.
// Depends on kfdd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface kfdd_in_if;
  logic                          valid;
  logic                          ready;
  logic [kfdd_pkg::KURT_W-1:0]   kurtosis_value;
  logic [kfdd_pkg::FACTOR_W-1:0] sigma_factor;
  logic                          sub_frame_end;

  modport source(output valid, output kurtosis_value, output sigma_factor,
                 output sub_frame_end, input ready);
  modport sink(input valid, input kurtosis_value, input sigma_factor,
               input sub_frame_end, output ready);
endinterface
`default_nettype wire

### hw/rtl/kfdd_out_if.sv
// Decision channel of the kurtosis frame drop decider: valid, ready, payload.
// Depends on kfdd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface kfdd_out_if;
  logic                           valid;
  logic                           ready;
  logic                           frame_pass;
  logic [kfdd_pkg::CUT_SLOTS-1:0] failed_cuts;

  modport source(output valid, output frame_pass, output failed_cuts,
                 input ready);
  modport sink(input valid, input frame_pass, input failed_cuts,
               output ready);
endinterface
`default_nettype wire

### hw/rtl/kfdd_sigma_stage.sv
// Input register and sigma multiplier stage of the frame drop decider.
// Depends on kfdd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kfdd_sigma_stage (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [kfdd_pkg::KURT_W-1:0]   kurtosis_value,
  input  wire logic [kfdd_pkg::FACTOR_W-1:0] sigma_factor,
  input  wire logic                          sub_frame_end,
  output logic                               item_valid,
  output kfdd_pkg::sigma_item_t              item
);

  localparam int PROD_W = kfdd_pkg::KURT_W + kfdd_pkg::FACTOR_W;

  logic                          in_reg_valid;
  logic [kfdd_pkg::KURT_W-1:0]   sk;
  logic [kfdd_pkg::FACTOR_W-1:0] factor;
  logic                          last;
  logic [kfdd_pkg::KURT_W-1:0]   deviation;
  logic [PROD_W-1:0]             product;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      item_valid   <= 1'b0;
    end else if (en) begin
      in_reg_valid <= in_valid;
      item_valid   <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sk         <= kurtosis_value;
      factor     <= sigma_factor;
      last       <= sub_frame_end;
      item.sigma <= product[PROD_W-1:16];
      item.last  <= last;
    end
  end

  // |sk - 1| fits in 20 bits either way; the Q16.24 product drops 16 bits.
  always_comb begin
    if (sk >= kfdd_pkg::ONE_Q16) begin
      deviation = sk - kfdd_pkg::ONE_Q16;
    end else begin
      deviation = kfdd_pkg::ONE_Q16 - sk;
    end
    product = PROD_W'(deviation) * PROD_W'(factor);
  end

endmodule
`default_nettype wire

### hw/rtl/kfdd_cut_counter.sv
// Per-cut exceed counters and the end-of-sub-frame decision.
// Depends on kfdd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kfdd_cut_counter #(
  parameter int MAX_CUTS    = 3,
  parameter int SAMPLES_MAX = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  item_valid,
  input  wire kfdd_pkg::sigma_item_t item,
  input  wire kfdd_pkg::cfg_t        cfg,
  output logic                       res_valid,
  output kfdd_pkg::result_t          res
);

  localparam int CNT_W = $clog2(SAMPLES_MAX + 1);
  localparam int CMP_W = (CNT_W > kfdd_pkg::LIMIT_W) ? CNT_W : kfdd_pkg::LIMIT_W;
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(SAMPLES_MAX);
  localparam logic [kfdd_pkg::CUT_COUNT_W-1:0] CUTS_BUILT =
    kfdd_pkg::CUT_COUNT_W'(MAX_CUTS);

  logic [CNT_W-1:0]                  counts      [MAX_CUTS];
  logic [CNT_W-1:0]                  counts_next [MAX_CUTS];
  logic [kfdd_pkg::CUT_COUNT_W-1:0]  active_n;
  logic [MAX_CUTS-1:0]               active;
  logic [MAX_CUTS-1:0]               bump;
  logic [MAX_CUTS-1:0]               failed;
  logic                              step;

  assign step = en && item_valid;

  always_comb begin
    active_n = (cfg.cut_count > CUTS_BUILT) ? CUTS_BUILT : cfg.cut_count;
    for (int k = 0; k < MAX_CUTS; k++) begin
      active[k] = kfdd_pkg::CUT_COUNT_W'(k) < active_n;
      // Counters saturate at the sample limit.
      bump[k]   = active[k] && (item.sigma > cfg.thresholds[k]) &&
                  (counts[k] != CNT_SAT);
      counts_next[k] = counts[k] + CNT_W'(bump[k]);
      failed[k] = active[k] &&
                  (CMP_W'(counts_next[k]) > CMP_W'(cfg.limits[k]));
    end
  end

  assign res_valid       = step && item.last;
  assign res.failed_cuts = kfdd_pkg::CUT_SLOTS'(failed);
  assign res.frame_pass  = (failed == '0) || !cfg.drop_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_CUTS; k++) begin
        counts[k] <= '0;
      end
    end else if (step) begin
      for (int k = 0; k < MAX_CUTS; k++) begin
        counts[k] <= item.last ? '0 : counts_next[k];
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/kfdd_out_buffer.sv
// Two-entry output register with skid slot for decision words.
// Depends on kfdd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "kurtosis_frame_drop_decider_top_macros.svh"
module kfdd_out_buffer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire kfdd_pkg::result_t push_data,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output kfdd_pkg::result_t      out_data,
  output logic                   skid_valid
);

  kfdd_pkg::result_t skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (!out_valid) begin
      if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  `KFDD_ASSERT_IMPLY(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `KFDD_ASSERT_IMPLY(a_no_push_when_full, clk, rst, push, !skid_valid)
  `KFDD_ASSERT_NEXT(a_skid_drains, clk, rst, skid_valid && out_ready, !skid_valid)

endmodule
`default_nettype wire

### hw/rtl/kurtosis_frame_drop_decider_top.sv
// Top level of the spectral kurtosis sub-frame drop decider.
// Depends on kfdd_pkg, kfdd_in_if, kfdd_out_if and the kfdd_* submodules.
//
// Usage: kurtosis samples enter on the samples channel, one word per sample,
// each carrying the sigma scale and a flag marking the last sample of a
// sub-frame. For every sample the block forms |scale * (sk - 1)| and counts,
// per active cut, the samples above that cut's threshold. The last sample of
// a sub-frame produces one word on the decisions channel: the failed cuts
// and whether the sub-frame is forwarded; the counters then clear.
// Throughput is one sample per cycle while the output buffer has a free slot.
// A sample loads the input register, then the multiplier register; a closing
// sample's decision, formed by the counter update, then loads the output
// register. The output has a two-word buffer, so samples keep flowing while
// a decision waits; ready on the samples channel drops only once a second
// decision is held behind a stalled receiver, and the whole pipeline then
// holds. Reset (synchronous, active high) clears the configuration registers,
// counters and the pipeline valid bits. Configuration is written through
// cfg_we, cfg_index and cfg_data, one register per cycle; the user must write
// it only while the block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none
module kurtosis_frame_drop_decider_top #(
  parameter int MAX_CUTS    = 3,
  parameter int SAMPLES_MAX = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  kfdd_in_if.sink                              samples,
  kfdd_out_if.source                           decisions,
  input  wire logic                            cfg_we,
  input  wire logic [kfdd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kfdd_pkg::CFG_DATA_W-1:0] cfg_data
);

  kfdd_pkg::cfg_t        cfg;
  kfdd_pkg::sigma_item_t item;
  kfdd_pkg::result_t     res;
  kfdd_pkg::result_t     out_data;
  logic                  item_valid;
  logic                  res_valid;
  logic                  skid_valid;
  logic                  en;

  // The pipeline moves whenever the output buffer has a free slot.
  assign en            = !skid_valid;
  assign samples.ready = en;

  // Configuration registers; every index of the port names a register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (kfdd_pkg::cfg_reg_t'(cfg_index))
        kfdd_pkg::REG_DROP_ENABLE: cfg.drop_enable   <= cfg_data[0];
        kfdd_pkg::REG_CUT_COUNT:   cfg.cut_count     <= cfg_data[kfdd_pkg::CUT_COUNT_W-1:0];
        kfdd_pkg::REG_THRESHOLD_A: cfg.thresholds[0] <= cfg_data[kfdd_pkg::THRESH_W-1:0];
        kfdd_pkg::REG_THRESHOLD_B: cfg.thresholds[1] <= cfg_data[kfdd_pkg::THRESH_W-1:0];
        kfdd_pkg::REG_THRESHOLD_C: cfg.thresholds[2] <= cfg_data[kfdd_pkg::THRESH_W-1:0];
        kfdd_pkg::REG_LIMIT_A:     cfg.limits[0]     <= cfg_data[kfdd_pkg::LIMIT_W-1:0];
        kfdd_pkg::REG_LIMIT_B:     cfg.limits[1]     <= cfg_data[kfdd_pkg::LIMIT_W-1:0];
        kfdd_pkg::REG_LIMIT_C:     cfg.limits[2]     <= cfg_data[kfdd_pkg::LIMIT_W-1:0];
      endcase
    end
  end

  kfdd_sigma_stage u_sigma (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (samples.valid),
    .kurtosis_value (samples.kurtosis_value),
    .sigma_factor   (samples.sigma_factor),
    .sub_frame_end  (samples.sub_frame_end),
    .item_valid     (item_valid),
    .item           (item)
  );

  kfdd_cut_counter #(
    .MAX_CUTS    (MAX_CUTS),
    .SAMPLES_MAX (SAMPLES_MAX)
  ) u_counter (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .item_valid (item_valid),
    .item       (item),
    .cfg        (cfg),
    .res_valid  (res_valid),
    .res        (res)
  );

  kfdd_out_buffer u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res),
    .out_ready  (decisions.ready),
    .out_valid  (decisions.valid),
    .out_data   (out_data),
    .skid_valid (skid_valid)
  );

  assign decisions.frame_pass  = out_data.frame_pass;
  assign decisions.failed_cuts = out_data.failed_cuts;

endmodule
`default_nettype wire
